// File: rtl/rspp_pkg.sv
// Shared constants and types for the rotated seam pixel plotter.
package rspp_pkg;

  localparam int VISIBLE_COLUMNS_DEF = 792;
  localparam int DRIVER_COLUMNS_DEF  = 800;
  localparam int PANEL_ROWS_DEF      = 272;

  localparam int CFG_W = 10;

  localparam logic [1:0] OP_PLOT  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_SEAM_COLUMN = 1'b0;
  localparam logic REG_SEAM_GAP    = 1'b1;

  localparam logic [9:0] SEAM_COLUMN_RESET = 10'd396;
  localparam logic [5:0] SEAM_GAP_RESET    = 6'd8;

  localparam logic [7:0] WHITE_BYTE   = 8'hFF;
  localparam logic [7:0] MASK_MSB     = 8'h80;
  localparam logic       COLOUR_BLACK = 1'b1;

  typedef struct packed {
    logic       keep;
    logic [7:0] mask;
  } pix_ctl_t;

endpackage

// File: rtl/rspp_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
module rspp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rspp_map.sv
// Maps a visible pixel coordinate to a frame store byte address and bit mask.
module rspp_map #(
  parameter int VISIBLE_COLUMNS = rspp_pkg::VISIBLE_COLUMNS_DEF,
  parameter int DRIVER_COLUMNS  = rspp_pkg::DRIVER_COLUMNS_DEF,
  parameter int PANEL_ROWS      = rspp_pkg::PANEL_ROWS_DEF,
  parameter int AW              = 15
) (
  input  logic signed [15:0] pixel_x,
  input  logic signed [15:0] pixel_y,
  input  logic [9:0]         seam_column,
  input  logic [5:0]         seam_gap,
  output logic [AW-1:0]      addr,
  output rspp_pkg::pix_ctl_t ctl
);

  import rspp_pkg::*;

  localparam int ROW_BYTES = (DRIVER_COLUMNS + 7) / 8;
  localparam int CW        = $clog2(DRIVER_COLUMNS + VISIBLE_COLUMNS + 64);
  localparam int RW        = $clog2(PANEL_ROWS + 1);

  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic [CW-1:0]      xn;
  logic [CW-1:0]      shifted;
  logic [CW-1:0]      dx;
  logic [RW-1:0]      yn;
  logic [RW-1:0]      dy;
  logic               in_area;
  logic               past_driver;
  logic [AW-1:0]      row_base;

  assign xs = 32'(pixel_x);
  assign ys = 32'(pixel_y);

  assign in_area = !pixel_x[15] && !pixel_y[15] &&
                   (xs < VISIBLE_COLUMNS) && (ys < PANEL_ROWS);

  assign xn = xs[CW-1:0];
  assign yn = ys[RW-1:0];

  assign shifted = (32'(xn) >= 32'(seam_column)) ? xn + CW'(seam_gap) : xn;
  assign past_driver = 32'(shifted) >= 32'(DRIVER_COLUMNS);

  assign dx = CW'(DRIVER_COLUMNS - 1) - shifted;
  assign dy = RW'(PANEL_ROWS - 1) - yn;

  assign row_base = AW'(dy) * AW'(ROW_BYTES);
  assign addr     = row_base + AW'(dx >> 3);

  assign ctl.keep = in_area && !past_driver;
  assign ctl.mask = MASK_MSB >> dx[2:0];

endmodule

// File: rtl/rotated_seam_pixel_plotter.sv
// Top level of the rotated seam pixel plotter: control sequencer and frame store.
// One-bit-per-pixel frame store in a single synchronous RAM, served one item at
// a time. A plot steps through accept, map, fetch and write back over the RAM's
// read-modify-write path, or ends after the map when the point is dropped; a read
// steps through accept, map, fetch and output, plus any wait for the output register
// to free up; a clear writes ROW_BYTES * PANEL_ROWS bytes, one byte per cycle
// through the single write port. The store contents are undefined until the
// first clear. The seam registers may only be written while no item is in flight.
module rotated_seam_pixel_plotter #(
  parameter int VISIBLE_COLUMNS = rspp_pkg::VISIBLE_COLUMNS_DEF,
  parameter int DRIVER_COLUMNS  = rspp_pkg::DRIVER_COLUMNS_DEF,
  parameter int PANEL_ROWS      = rspp_pkg::PANEL_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [rspp_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic signed [15:0]         pixel_x,
  input  logic signed [15:0]         pixel_y,
  input  logic                       colour,
  input  logic [14:0]                read_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 read_byte
);

  import rspp_pkg::*;

  localparam int ROW_BYTES   = (DRIVER_COLUMNS + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_ROWS;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [9:0]         seam_column;
  logic [5:0]         seam_gap;
  logic [1:0]         op;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic               col;
  logic [14:0]        raddr_in;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      addr_next;
  logic [7:0]         mask;
  logic               read_ok;
  logic [AW-1:0]      map_addr;
  pix_ctl_t           map_ctl;
  logic [31:0]        raddr_ext;
  logic               ram_we;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [7:0]         ram_rdata;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign raddr_ext = 32'(raddr_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      seam_column <= SEAM_COLUMN_RESET;
      seam_gap    <= SEAM_GAP_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_SEAM_COLUMN) begin
        seam_column <= cfg_data[9:0];
      end else begin
        seam_gap <= cfg_data[5:0];
      end
    end
  end

  rspp_map #(
    .VISIBLE_COLUMNS(VISIBLE_COLUMNS),
    .DRIVER_COLUMNS (DRIVER_COLUMNS),
    .PANEL_ROWS     (PANEL_ROWS),
    .AW             (AW)
  ) u_map (
    .pixel_x    (px),
    .pixel_y    (py),
    .seam_column(seam_column),
    .seam_gap   (seam_gap),
    .addr       (map_addr),
    .ctl        (map_ctl)
  );

  always_comb begin
    state_next = state;
    addr_next  = addr;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        unique case (op)
          OP_PLOT: begin
            addr_next  = map_addr;
            state_next = map_ctl.keep ? S_FETCH : S_IDLE;
          end
          OP_CLEAR: begin
            addr_next  = '0;
            state_next = S_CLEAR;
          end
          OP_READ: begin
            addr_next  = raddr_ext[AW-1:0];
            state_next = (raddr_ext < 32'(STORE_BYTES)) ? S_FETCH : S_OUT;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FETCH: state_next = (op == OP_PLOT) ? S_MOD : S_OUT;
      S_MOD:   state_next = S_IDLE;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (addr == AW'(STORE_BYTES - 1)) begin
          state_next = S_IDLE;
        end else begin
          addr_next = addr + AW'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    if (in_valid && in_ready) begin
      op       <= operation;
      px       <= pixel_x;
      py       <= pixel_y;
      col      <= colour;
      raddr_in <= read_address;
    end
    if (state == S_CALC) begin
      mask    <= map_ctl.mask;
      read_ok <= raddr_ext < 32'(STORE_BYTES);
    end
  end

  assign ram_re    = (state == S_FETCH);
  assign ram_we    = (state == S_MOD) || (state == S_CLEAR);
  assign ram_wdata = (state == S_CLEAR)    ? WHITE_BYTE :
                     (col == COLOUR_BLACK) ? (ram_rdata & ~mask) : (ram_rdata | mask);

  rspp_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      read_byte <= read_ok ? ram_rdata : 8'h00;
    end
  end

  a_mod_after_fetch: assert property (@(posedge clk) disable iff (rst)
    state == S_MOD |-> $past(state == S_FETCH))
    else $error("write back without a fresh fetch");

  a_clear_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> 32'(addr) < 32'(STORE_BYTES))
    else $error("clear sweep past end of store");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT && op == OP_READ))
    else $error("result raised outside a read");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready)
    else $error("item accepted while busy");

endmodule
